// File: rtl/core/pqad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pqad_pkg;

    localparam int TAG_W   = 32;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 40;
    localparam int ROOT_W  = 20;
    localparam int CFG_W   = 7;
    localparam int SUB_W_IN  = 6;
    localparam int CENT_W_IN = 8;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 96;

    localparam int MAX_SUBSPACES_DEF          = 64;
    localparam int CENTROIDS_PER_SUBSPACE_DEF = 256;

    localparam logic [CFG_W-1:0] NUM_SUBSPACES_RST = 7'd8;
    localparam logic [SUM_W-1:0] SUM_MAX           = {SUM_W{1'b1}};
    localparam logic [SUM_W-1:0] ROOT_BIT_INIT     = 40'h40_0000_0000;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CODE  = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [SUM_W-1:0] sum;
        logic             sat;
    } job_t;

    typedef enum logic {
        SQRT_IDLE,
        SQRT_RUN
    } sqrt_state_t;

endpackage

`default_nettype wire

// File: rtl/core/pqad_table_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module pqad_table_mem #(
    parameter int MAX_SUBSPACES          = pqad_pkg::MAX_SUBSPACES_DEF,
    parameter int CENTROIDS_PER_SUBSPACE = pqad_pkg::CENTROIDS_PER_SUBSPACE_DEF,
    localparam int SUB_W  = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1,
    localparam int CENT_W = (CENTROIDS_PER_SUBSPACE > 1) ? $clog2(CENTROIDS_PER_SUBSPACE) : 1,
    localparam int ADDR_W = SUB_W + CENT_W
) (
    input  wire logic                              clk,
    input  wire logic                              wr_req,
    input  wire logic [pqad_pkg::SUB_W_IN-1:0]     wr_sub,
    input  wire logic [pqad_pkg::CENT_W_IN-1:0]    wr_cent,
    input  wire logic [pqad_pkg::VALUE_W-1:0]      wr_value,
    input  wire logic                              rd_en,
    input  wire logic [ADDR_W-1:0]                 rd_addr,
    output logic      [pqad_pkg::VALUE_W-1:0]      rd_data
);

    localparam int DEPTH  = 1 << ADDR_W;

    logic [pqad_pkg::VALUE_W-1:0] mem [DEPTH];
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [pqad_pkg::VALUE_W-1:0] rd_data_reg;

    // drop writes outside the table
    assign wr_en = wr_req
                && ({1'b0, wr_sub} < (pqad_pkg::SUB_W_IN + 1)'(MAX_SUBSPACES))
                && ({1'b0, wr_cent} < (pqad_pkg::CENT_W_IN + 1)'(CENTROIDS_PER_SUBSPACE));
    assign wr_addr = {wr_sub[SUB_W-1:0], wr_cent[CENT_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/pqad_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module pqad_accum #(
    parameter int MAX_SUBSPACES          = pqad_pkg::MAX_SUBSPACES_DEF,
    parameter int CENTROIDS_PER_SUBSPACE = pqad_pkg::CENTROIDS_PER_SUBSPACE_DEF,
    localparam int SUB_W  = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1,
    localparam int CENT_W = (CENTROIDS_PER_SUBSPACE > 1) ? $clog2(CENTROIDS_PER_SUBSPACE) : 1,
    localparam int ADDR_W = SUB_W + CENT_W
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [pqad_pkg::CFG_W-1:0]        num_subspaces,
    input  wire logic                              code_accept,
    input  wire logic [pqad_pkg::CENT_W_IN-1:0]    code_cent,
    input  wire logic [pqad_pkg::TAG_W-1:0]        code_tag,
    output logic                                   ready,
    output logic                                   rd_en,
    output logic      [ADDR_W-1:0]                 rd_addr,
    input  wire logic [pqad_pkg::VALUE_W-1:0]      rd_data,
    output logic                                   job_valid,
    input  wire logic                              job_ready,
    output pqad_pkg::job_t                         job
);

    localparam int CW     = pqad_pkg::CFG_W;
    localparam int SW     = pqad_pkg::SUM_W;

    logic [SUB_W-1:0]             pos_reg;
    logic [SUB_W-1:0]             pos_next;
    logic                         s1_valid_reg;
    logic                         s1_last_reg;
    logic                         s1_hit_reg;
    logic [pqad_pkg::TAG_W-1:0]   s1_tag_reg;
    logic [SW-1:0]                sum_reg;
    logic [SW-1:0]                sum_next;
    logic                         sat_reg;
    logic                         sat_next;

    logic [CW-1:0]                eff_count;
    logic                         code_last;
    logic                         code_hit;
    logic                         advance;
    logic                         s1_fire;
    logic [SW-1:0]                add_value;
    logic [SW:0]                  sum_wide;
    logic                         sum_ovf;
    logic [SW-1:0]                sum_sat;
    logic                         sat_upd;

    always_comb
    begin
        if (num_subspaces == '0)
        begin
            eff_count = CW'(1);
        end
        else if (num_subspaces > CW'(MAX_SUBSPACES))
        begin
            eff_count = CW'(MAX_SUBSPACES);
        end
        else
        begin
            eff_count = num_subspaces;
        end
    end

    assign code_last = (CW'(pos_reg) + CW'(1)) >= eff_count;
    assign code_hit  = {1'b0, code_cent} < (pqad_pkg::CENT_W_IN + 1)'(CENTROIDS_PER_SUBSPACE);

    // hold the pending element while the root unit is busy with a finished vector
    assign advance = !s1_valid_reg || !s1_last_reg || job_ready;
    assign s1_fire = s1_valid_reg && advance;
    assign ready   = advance;

    assign rd_en   = code_accept;
    assign rd_addr = {pos_reg, code_cent[CENT_W-1:0]};

    assign add_value = s1_hit_reg ? SW'(rd_data) : '0;
    assign sum_wide  = {1'b0, sum_reg} + {1'b0, add_value};
    assign sum_ovf   = sum_wide[SW];
    assign sum_sat   = sum_ovf ? pqad_pkg::SUM_MAX : sum_wide[SW-1:0];
    assign sat_upd   = sat_reg | sum_ovf;

    assign job_valid = s1_valid_reg && s1_last_reg;
    assign job.tag   = s1_tag_reg;
    assign job.sum   = sum_sat;
    assign job.sat   = sat_upd;

    always_comb
    begin
        pos_next = pos_reg;
        if (code_accept)
        begin
            pos_next = code_last ? '0 : pos_reg + SUB_W'(1);
        end
        sum_next = sum_reg;
        sat_next = sat_reg;
        if (s1_fire)
        begin
            sum_next = s1_last_reg ? '0 : sum_sat;
            sat_next = s1_last_reg ? 1'b0 : sat_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
            sat_reg      <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            sat_reg <= sat_next;
            if (advance)
            begin
                s1_valid_reg <= code_accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (code_accept)
        begin
            s1_last_reg <= code_last;
            s1_hit_reg  <= code_hit;
            s1_tag_reg  <= code_tag;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pqad_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module pqad_isqrt (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            job_valid,
    output logic                                 job_ready,
    input  wire pqad_pkg::job_t                  job,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic     [pqad_pkg::TAG_W-1:0]       out_tag,
    output logic     [pqad_pkg::SUM_W-1:0]       out_sum,
    output logic     [pqad_pkg::ROOT_W-1:0]      out_root,
    output logic                                 out_sat
);

    localparam int SW = pqad_pkg::SUM_W;

    pqad_pkg::sqrt_state_t state_reg;
    pqad_pkg::sqrt_state_t state_next;

    pqad_pkg::job_t             job_reg;
    logic [SW-1:0]              rem_reg;
    logic [SW-1:0]              root_reg;
    logic [SW-1:0]              bit_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [pqad_pkg::TAG_W-1:0] out_tag_reg;
    logic [SW-1:0]              out_sum_reg;
    logic [pqad_pkg::ROOT_W-1:0] out_root_reg;
    logic                       out_sat_reg;

    logic [SW-1:0]              trial;
    logic                       take;
    logic [SW-1:0]              rem_step;
    logic [SW-1:0]              root_step;
    logic                       out_free;
    logic                       load;
    logic                       step;
    logic                       finish;

    assign trial     = root_reg + bit_reg;
    assign take      = rem_reg >= trial;
    assign rem_step  = take ? rem_reg - trial : rem_reg;
    assign root_step = take ? (root_reg >> 1) + bit_reg : root_reg >> 1;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        job_ready      = 1'b0;
        load           = 1'b0;
        step           = 1'b0;
        finish         = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            pqad_pkg::SQRT_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    load       = 1'b1;
                    state_next = pqad_pkg::SQRT_RUN;
                end
            end
            pqad_pkg::SQRT_RUN:
            begin
                // stall the final step until the output register frees up
                if (!bit_reg[0] || out_free)
                begin
                    step = 1'b1;
                end
                if (bit_reg[0] && out_free)
                begin
                    finish         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = pqad_pkg::SQRT_IDLE;
                end
            end
            default:
            begin
                state_next = pqad_pkg::SQRT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pqad_pkg::SQRT_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg  <= job;
            rem_reg  <= job.sum;
            root_reg <= '0;
            bit_reg  <= pqad_pkg::ROOT_BIT_INIT;
        end
        else if (step)
        begin
            rem_reg  <= rem_step;
            root_reg <= root_step;
            bit_reg  <= bit_reg >> 2;
        end
        if (finish)
        begin
            out_tag_reg  <= job_reg.tag;
            out_sum_reg  <= job_reg.sum;
            out_root_reg <= root_step[pqad_pkg::ROOT_W-1:0];
            out_sat_reg  <= job_reg.sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;
    assign out_sum   = out_sum_reg;
    assign out_root  = out_root_reg;
    assign out_sat   = out_sat_reg;

endmodule

`default_nettype wire

// File: rtl/core/pq_asymmetric_distance.sv
// Throughput: one input beat per cycle while s_tready is high; the 20-step iterative
// square root unit takes one vector at a time; a vector waiting for it stalls the input.
// Reset: asynchronous, active low; clears the running sum, code position, overflow flag and
// handshake state, and sets num_subspaces to 8. Table memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module pq_asymmetric_distance #(
    parameter int MAX_SUBSPACES          = pqad_pkg::MAX_SUBSPACES_DEF,
    parameter int CENTROIDS_PER_SUBSPACE = pqad_pkg::CENTROIDS_PER_SUBSPACE_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wen,
    input  wire logic [pqad_pkg::CFG_W-1:0]          cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // sub_index[5:0], centroid[13:6], entry_value[45:14], vector_tag[77:46], zero pad
    input  wire logic [pqad_pkg::S_TDATA_W-1:0]      s_tdata,
    // kind[0]
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // result_tag[31:0], squared_distance[71:32], root_distance[91:72], saturated[92], zero pad
    output logic      [pqad_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int SUB_W  = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1;
    localparam int CENT_W = (CENTROIDS_PER_SUBSPACE > 1) ? $clog2(CENTROIDS_PER_SUBSPACE) : 1;
    localparam int ADDR_W = SUB_W + CENT_W;

    logic [pqad_pkg::CFG_W-1:0]     num_subspaces_reg;

    logic [pqad_pkg::SUB_W_IN-1:0]  in_sub;
    logic [pqad_pkg::CENT_W_IN-1:0] in_cent;
    logic [pqad_pkg::VALUE_W-1:0]   in_value;
    logic [pqad_pkg::TAG_W-1:0]     in_tag;
    logic                           beat;
    logic                           wr_req;
    logic                           code_accept;

    logic                           rd_en;
    logic [ADDR_W-1:0]              rd_addr;
    logic [pqad_pkg::VALUE_W-1:0]   rd_data;

    logic                           job_valid;
    logic                           job_ready;
    pqad_pkg::job_t                 job;

    logic [pqad_pkg::TAG_W-1:0]     out_tag;
    logic [pqad_pkg::SUM_W-1:0]     out_sum;
    logic [pqad_pkg::ROOT_W-1:0]    out_root;
    logic                           out_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_subspaces_reg <= pqad_pkg::NUM_SUBSPACES_RST;
        end
        else if (cfg_wen)
        begin
            num_subspaces_reg <= cfg_wdata;
        end
    end

    assign in_sub   = s_tdata[5:0];
    assign in_cent  = s_tdata[13:6];
    assign in_value = s_tdata[45:14];
    assign in_tag   = s_tdata[77:46];

    assign beat        = s_tvalid && s_tready;
    assign wr_req      = beat && (s_tuser == pqad_pkg::KIND_WRITE);
    assign code_accept = beat && (s_tuser == pqad_pkg::KIND_CODE);

    pqad_table_mem #(
        .MAX_SUBSPACES          (MAX_SUBSPACES),
        .CENTROIDS_PER_SUBSPACE (CENTROIDS_PER_SUBSPACE)
    ) u_table_mem (
        .clk      (clk),
        .wr_req   (wr_req),
        .wr_sub   (in_sub),
        .wr_cent  (in_cent),
        .wr_value (in_value),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    pqad_accum #(
        .MAX_SUBSPACES          (MAX_SUBSPACES),
        .CENTROIDS_PER_SUBSPACE (CENTROIDS_PER_SUBSPACE)
    ) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .num_subspaces (num_subspaces_reg),
        .code_accept   (code_accept),
        .code_cent     (in_cent),
        .code_tag      (in_tag),
        .ready         (s_tready),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .job_valid     (job_valid),
        .job_ready     (job_ready),
        .job           (job)
    );

    pqad_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tag   (out_tag),
        .out_sum   (out_sum),
        .out_root  (out_root),
        .out_sat   (out_sat)
    );

    assign m_tdata = {3'b000, out_sat, out_root, out_sum, out_tag};

endmodule

`default_nettype wire
